// ===== rtl/icce_pkg.sv =====
package icce_pkg;

	// image and window limits
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_KERNEL = 7;

	localparam int X_W        = $clog2(MAX_WIDTH);
	localparam int Y_W        = $clog2(MAX_HEIGHT);
	localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int PIX_AW     = $clog2(PIX_DEPTH);
	localparam int COEF_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int COEF_AW    = $clog2(COEF_DEPTH);

	// field widths
	localparam int DIM_W  = 7;
	localparam int K_W    = 3;
	localparam int PIX_W  = 32;
	localparam int COEF_W = 16;
	localparam int CH_W   = 2;
	localparam int NUM_CH = 3;

	// arithmetic widths: q16.16 times q4.12, up to 49 terms
	localparam int FRAC_BITS = 12;
	localparam int PROD_W    = PIX_W + COEF_W;
	localparam int ACC_W     = 54;
	localparam int Q_W       = ACC_W - FRAC_BITS;

	// command codes
	localparam logic [1:0] CMD_LOAD_COEFF = 2'd0;
	localparam logic [1:0] CMD_LOAD_PIXEL = 2'd1;
	localparam logic [1:0] CMD_COMPUTE    = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_KERNEL_SIZE  = 2'd2;
	localparam logic [1:0] REG_MONO_MODE    = 2'd3;

	typedef struct packed {
		logic [1:0]              command;
		logic [5:0]              pos_x;
		logic [5:0]              pos_y;
		logic [PIX_W-1:0]        pixel_value;
		logic [2:0]              kernel_col;
		logic [2:0]              kernel_row;
		logic signed [COEF_W-1:0] coeff;
	} icce_req_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             saturated;
	} icce_res_t;

	// control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic            clear;
		logic            issue;
		logic [CH_W-1:0] ch;
		logic            mono;
	} icce_mac_ctl_t;

	typedef logic [NUM_CH-1:0][ACC_W-1:0] icce_acc_vec_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FIN
	} icce_state_t;

endpackage

// ===== rtl/icce_ram.sv =====
module icce_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/icce_mac.sv =====
module icce_mac
	import icce_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  icce_mac_ctl_t            ctl,
	input  logic [PIX_W-1:0]         pix_rdata,
	input  logic [COEF_W-1:0]        coef_rdata,
	output icce_acc_vec_t            acc,
	output logic                     pipe_busy
);

	logic              vld_s1;
	logic [CH_W-1:0]   ch_s1;
	logic              mono_s1;
	logic              vld_s2;
	logic [CH_W-1:0]   ch_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [PIX_W-1:0]  op_pix;
	logic signed [COEF_W-1:0] op_coef;
	logic signed [ACC_W-1:0]  acc_sel;
	logic signed [ACC_W-1:0]  acc_sum;
	icce_acc_vec_t            acc_q;

	// s1: ram data arrives, pick the operand
	always_comb begin
		if (mono_s1) begin
			op_pix = $signed(pix_rdata);
		end else begin
			op_pix = $signed({{(PIX_W-8){1'b0}}, pix_rdata[ch_s1*8 +: 8]});
		end
		op_coef = $signed(coef_rdata);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ch_s1   <= ctl.ch;
		mono_s1 <= ctl.mono;
		ch_s2   <= ch_s1;
		prod_s2 <= op_pix * op_coef;
	end

	// s2: one shared adder into the selected channel
	assign acc_sel = $signed(acc_q[ch_s2]);
	assign acc_sum = acc_sel + ACC_W'(prod_s2);

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q[ch_s2] <= acc_sum;
		end
	end

	assign acc       = acc_q;
	assign pipe_busy = vld_s1 | vld_s2;

endmodule

// ===== rtl/image_convolution_clamped_edge.sv =====
// compute: after the accepting edge the sequencer issues k*k*C taps, C = 1 mono, 3 rgba,
// to the shared multiply-accumulate at one product per cycle, then drains its pipeline
// and passes through the finish state before done strobes; a kernel size of 0 skips the taps
// loads never raise busy; the next request is taken while done shows
// the receiver cannot stall: done is high for a single cycle; result holds until the next finish
// arst_n clears control and config (64, 64, 3, rgba); image and coefficient rams are not cleared
module image_convolution_clamped_edge
	import icce_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  icce_req_t  request,
	output logic       done,
	output icce_res_t  result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	// configuration registers
	logic [DIM_W-1:0] image_width_q;
	logic [DIM_W-1:0] image_height_q;
	logic [K_W-1:0]   kernel_size_q;
	logic             mono_mode_q;

	// sequencer
	icce_state_t      state_q;
	icce_state_t      state_d;
	logic [K_W-1:0]   i_q;
	logic [K_W-1:0]   j_q;
	logic [CH_W-1:0]  ch_q;
	logic [X_W-1:0]   pos_x_q;
	logic [Y_W-1:0]   pos_y_q;

	logic             accept;
	logic             compute_go;
	logic             issue;
	logic             last_ch;
	logic             last_j;
	logic             last_i;
	logic             last_tap;

	// window addressing
	logic [K_W-1:0]   half;
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;
	logic [X_W-1:0]   w_m1;
	logic [Y_W-1:0]   h_m1;
	logic [X_W+2:0]   sx_raw;
	logic [Y_W+2:0]   sy_raw;
	logic [X_W-1:0]   sx;
	logic [Y_W-1:0]   sy;

	// rams
	logic               pix_we;
	logic               coef_we;
	logic [PIX_AW-1:0]  pix_waddr;
	logic [PIX_AW-1:0]  pix_raddr;
	logic [COEF_AW-1:0] coef_waddr;
	logic [COEF_AW-1:0] coef_raddr;
	logic [PIX_W-1:0]   pix_rdata;
	logic [COEF_W-1:0]  coef_rdata;

	// mac and finish
	icce_mac_ctl_t    mac_ctl;
	icce_acc_vec_t    acc;
	logic             pipe_busy;
	icce_res_t        fin_res;
	icce_res_t        result_q;
	logic             done_q;

	assign accept     = start && !busy;
	assign compute_go = accept && (request.command == CMD_COMPUTE);

	// config writes are always taken; the user must write them only while idle, the block does not enforce this
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= DIM_W'(MAX_WIDTH);
			image_height_q <= DIM_W'(MAX_HEIGHT);
			kernel_size_q  <= K_W'(3);
			mono_mode_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				REG_KERNEL_SIZE:  kernel_size_q  <= cfg_data[K_W-1:0];
				REG_MONO_MODE:    mono_mode_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// image size as used: zero acts as one, oversize as the maximum
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (image_width_q > DIM_W'(MAX_WIDTH)) begin
			w_eff = DIM_W'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		if (image_height_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (image_height_q > DIM_W'(MAX_HEIGHT)) begin
			h_eff = DIM_W'(MAX_HEIGHT);
		end else begin
			h_eff = image_height_q;
		end
	end

	assign w_m1 = X_W'(w_eff - DIM_W'(1));
	assign h_m1 = Y_W'(h_eff - DIM_W'(1));
	assign half = kernel_size_q >> 1;

	// window coordinate, then clamp to the image edge
	assign sx_raw = (X_W+3)'(pos_x_q) + (X_W+3)'(i_q) - (X_W+3)'(half);
	assign sy_raw = (Y_W+3)'(pos_y_q) + (Y_W+3)'(j_q) - (Y_W+3)'(half);

	always_comb begin
		if (sx_raw[X_W+2]) begin
			sx = '0;
		end else if (sx_raw[X_W+1:0] > (X_W+2)'(w_m1)) begin
			sx = w_m1;
		end else begin
			sx = sx_raw[X_W-1:0];
		end
		if (sy_raw[Y_W+2]) begin
			sy = '0;
		end else if (sy_raw[Y_W+1:0] > (Y_W+2)'(h_m1)) begin
			sy = h_m1;
		end else begin
			sy = sy_raw[Y_W-1:0];
		end
	end

	// tap order: channel innermost, then row offset j, then column offset i
	assign last_ch  = mono_mode_q ? (ch_q == CH_W'(0)) : (ch_q == CH_W'(NUM_CH-1));
	assign last_j   = (j_q == kernel_size_q - K_W'(1));
	assign last_i   = (i_q == kernel_size_q - K_W'(1));
	assign last_tap = last_ch && last_j && last_i;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (compute_go) begin
					state_d = (kernel_size_q == '0) ? ST_DRAIN : ST_RUN;
				end
			end
			ST_RUN: begin
				if (last_tap) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!pipe_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy  = 1'b1;
		issue = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_RUN: begin
				issue = 1'b1;
			end
			ST_DRAIN, ST_FIN: begin
				busy = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			if (compute_go) begin
				i_q  <= '0;
				j_q  <= '0;
				ch_q <= '0;
			end else if (issue) begin
				if (last_ch) begin
					ch_q <= '0;
					if (last_j) begin
						j_q <= '0;
						i_q <= i_q + K_W'(1);
					end else begin
						j_q <= j_q + K_W'(1);
					end
				end else begin
					ch_q <= ch_q + CH_W'(1);
				end
			end
		end
	end

	// request position of the pixel being computed
	always_ff @(posedge clk) begin
		if (compute_go) begin
			pos_x_q <= request.pos_x;
			pos_y_q <= request.pos_y;
		end
	end

	// loads write straight from the request; out-of-range coefficient indexes are dropped
	assign pix_we     = accept && (request.command == CMD_LOAD_PIXEL);
	assign coef_we    = accept && (request.command == CMD_LOAD_COEFF) &&
	                    (request.kernel_col < K_W'(MAX_KERNEL)) &&
	                    (request.kernel_row < K_W'(MAX_KERNEL));
	assign pix_waddr  = {request.pos_y, request.pos_x};
	assign coef_waddr = COEF_AW'(request.kernel_row) * COEF_AW'(MAX_KERNEL) +
	                    COEF_AW'(request.kernel_col);
	assign pix_raddr  = {sy, sx};
	assign coef_raddr = COEF_AW'(j_q) * COEF_AW'(MAX_KERNEL) + COEF_AW'(i_q);

	icce_ram #(
		.WIDTH(PIX_W),
		.DEPTH(PIX_DEPTH)
	) u_pix_ram (
		.clk    (clk),
		.wr_en  (pix_we),
		.wr_addr(pix_waddr),
		.wr_data(request.pixel_value),
		.rd_en  (issue),
		.rd_addr(pix_raddr),
		.rd_data(pix_rdata)
	);

	icce_ram #(
		.WIDTH(COEF_W),
		.DEPTH(COEF_DEPTH)
	) u_coef_ram (
		.clk    (clk),
		.wr_en  (coef_we),
		.wr_addr(coef_waddr),
		.wr_data(request.coeff),
		.rd_en  (issue),
		.rd_addr(coef_raddr),
		.rd_data(coef_rdata)
	);

	// the mac pipeline lines its control up with the registered ram data
	assign mac_ctl.clear = compute_go;
	assign mac_ctl.issue = issue;
	assign mac_ctl.ch    = ch_q;
	assign mac_ctl.mono  = mono_mode_q;

	icce_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.pix_rdata (pix_rdata),
		.coef_rdata(coef_rdata),
		.acc       (acc),
		.pipe_busy (pipe_busy)
	);

	// finish: divide by 4096 toward zero, then saturate
	always_comb begin
		logic [Q_W-1:0]   q [NUM_CH];
		logic [Q_W-32:0]  top;
		logic             any_sat;
		logic [PIX_W-1:0] pix;
		any_sat = 1'b0;
		pix     = '0;
		for (int c = 0; c < NUM_CH; c++) begin
			q[c] = acc[c][ACC_W-1:FRAC_BITS] +
			       Q_W'(acc[c][ACC_W-1] && (|acc[c][FRAC_BITS-1:0]));
		end
		top = q[0][Q_W-1:31];
		if (mono_mode_q) begin
			if ((&top) || !(|top)) begin
				pix = q[0][PIX_W-1:0];
			end else begin
				any_sat = 1'b1;
				pix     = q[0][Q_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
			end
		end else begin
			pix[31:24] = 8'hff;
			for (int c = 0; c < NUM_CH; c++) begin
				if (q[c][Q_W-1]) begin
					any_sat      = 1'b1;
					pix[c*8 +: 8] = 8'h00;
				end else if (|q[c][Q_W-1:8]) begin
					any_sat      = 1'b1;
					pix[c*8 +: 8] = 8'hff;
				end else begin
					pix[c*8 +: 8] = q[c][7:0];
				end
			end
		end
		fin_res.out_pixel = pix;
		fin_res.saturated = any_sat;
	end

	// result register: one-cycle strobe, no back-pressure
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			result_q <= fin_res;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// a result only follows a finish cycle
	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("done without finish");

	// an accepted compute always makes the block busy next cycle
	a_compute_busy: assert property (@(posedge clk) disable iff (!arst_n)
		compute_go |=> busy)
		else $error("compute accepted but block not busy");

	// the accumulators are final when the finish cycle reads them
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !pipe_busy)
		else $error("finish with products still in flight");

	// window counters stay inside the kernel while issuing
	a_tap_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> ((i_q < kernel_size_q) && (j_q < kernel_size_q)))
		else $error("window counter out of range");

endmodule
